>>> hw/rtl/amrf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// amrf_pkg
// shared types and constants of the mixer register file: register indexes,
// reset values, access codes and the decoded control bundle
// ----------------------------------------------------------------------------
package amrf_pkg;

	// access codes
	localparam logic OP_READ   = 1'b0;
	localparam logic OP_WRITE  = 1'b1;
	localparam logic PORT_INDEX = 1'b0;
	localparam logic PORT_DATA  = 1'b1;

	// configuration register indexes
	localparam logic CFG_BASE_ADDRESS = 1'b0;
	localparam logic CFG_DSP_IRQ      = 1'b1;

	localparam logic [15:0] BASE_ADDRESS_RST = 16'h0220;
	localparam logic [3:0]  DSP_IRQ_RST      = 4'd7;

	// mixer register indexes
	localparam logic [7:0] IDX_RESET       = 8'h00;
	localparam logic [7:0] IDX_MASTER_MONO = 8'h02;
	localparam logic [7:0] IDX_VOICE       = 8'h04;
	localparam logic [7:0] IDX_FM_MONO     = 8'h06;
	localparam logic [7:0] IDX_CD_MONO     = 8'h08;
	localparam logic [7:0] IDX_MIC         = 8'h0A;
	localparam logic [7:0] IDX_IN_CTRL     = 8'h0C;
	localparam logic [7:0] IDX_OUT_CTRL    = 8'h0E;
	localparam logic [7:0] IDX_VOICE_ALT   = 8'h14;
	localparam logic [7:0] IDX_MASTER      = 8'h22;
	localparam logic [7:0] IDX_FM          = 8'h26;
	localparam logic [7:0] IDX_CD          = 8'h28;
	localparam logic [7:0] IDX_LINE        = 8'h2E;
	localparam logic [7:0] IDX_ALT30       = 8'h30;
	localparam logic [7:0] IDX_ALT32       = 8'h32;
	localparam logic [7:0] IDX_ALT36       = 8'h36;
	localparam logic [7:0] IDX_ALT38       = 8'h38;
	localparam logic [7:0] IDX_ALT3E       = 8'h3E;
	localparam logic [7:0] IDX_ID_CTRL     = 8'h40;

	// id sequence
	localparam logic [7:0] ID_BYTE0 = 8'h16;
	localparam logic [7:0] ID_BYTE1 = 8'h88;
	localparam logic [1:0] ID_PTR_B0 = 2'd0;
	localparam logic [1:0] ID_PTR_B1 = 2'd1;
	localparam logic [1:0] ID_PTR_B2 = 2'd2;

	localparam logic [7:0] VOL_DEFAULT_HI = 8'hEE;
	localparam logic [7:0] VOL_DEFAULT_LO = 8'h88;
	localparam logic [7:0] VOL_MASK_ST    = 8'hEE;
	localparam logic [7:0] VOL_MASK_MONO  = 8'h0E;
	localparam logic [7:0] UNMAPPED_READ  = 8'hFF;

	// mpu mode codes (bits 7:5 of the control register)
	localparam logic [2:0] MPU_MODE_OFF  = 3'd0;
	localparam logic [2:0] MPU_MODE_DSP  = 3'd2;
	localparam logic [2:0] MPU_MODE_IRQE = 3'd3;
	localparam logic [2:0] MPU_MODE_IRQA = 3'd4;
	localparam logic [2:0] MPU_MODE_IRQB = 3'd5;
	localparam logic [2:0] MPU_MODE_IRQC = 3'd6;
	localparam logic [2:0] MPU_MODE_IRQD = 3'd7;
	localparam logic [9:0] MPU_BASE_MIN  = 10'h300;
	localparam logic [9:0] JOYSTICK_BASE = 10'h200;

	// input source codes
	localparam logic [1:0] SRC_MIC  = 2'd0;
	localparam logic [1:0] SRC_CD   = 2'd1;
	localparam logic [1:0] SRC_LINE = 2'd2;
	localparam logic [1:0] SEL_CD   = 2'b01;
	localparam logic [1:0] SEL_LINE = 2'b11;

	// only the registers that can ever be observed are kept
	typedef struct packed {
		logic [7:0] r02;
		logic [7:0] r04;
		logic [7:0] r06;
		logic [7:0] r0a;
		logic [7:0] r0c;
		logic [7:0] r0e;
		logic [7:0] r22;
		logic [7:0] r26;
		logic [7:0] r28;
		logic [7:0] r2e;
		logic [7:0] r30;
		logic [7:0] r32;
		logic [7:0] r36;
		logic [7:0] r38;
		logic [7:0] r40;
	} mix_regs_t;

	localparam mix_regs_t MIX_RESET = '{
		r02: 8'h00, r04: VOL_DEFAULT_HI, r06: 8'h00, r0a: 8'h00,
		r0c: 8'h00, r0e: 8'h00, r22: VOL_DEFAULT_HI, r26: VOL_DEFAULT_HI,
		r28: VOL_DEFAULT_HI, r2e: 8'h00, r30: 8'h00, r32: VOL_DEFAULT_LO,
		r36: VOL_DEFAULT_LO, r38: 8'h00, r40: 8'h00
	};

	typedef struct packed {
		logic       stereo_on;
		logic       output_filter_on;
		logic       input_filter_on;
		logic       input_filter_high;
		logic [1:0] input_source;
		logic [9:0] mpu_base;
		logic [3:0] mpu_irq;
		logic [9:0] gameport_base;
	} ctl_t;

endpackage
`default_nettype wire

>>> hw/rtl/audio_mixer_register_file_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// audio_mixer_register_file_top
// mixer register file with index and data ports, id readout and control decode
// ----------------------------------------------------------------------------
// every accepted transaction (a read or write on the index or data port)
// updates the register state at its accepting edge and produces exactly one
// result, held in a single output register and presented the following cycle.
// one transaction is taken per clock; the only limit is that output register:
// in_stall rises only while a result is waiting and out_stall is high.
// the decoded controls reflect the registers after the transaction. the
// configuration port (base address, dsp irq) is always ready and should only
// be written while no transaction is in flight.
// ----------------------------------------------------------------------------
module audio_mixer_register_file_top (
	input  wire logic        clk,
	input  wire logic        arst_n,

	// access channel
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic        opcode,
	input  wire logic        port_select,
	input  wire logic [7:0]  write_data,

	// result channel
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [7:0]       read_data,
	output logic             stereo_on,
	output logic             output_filter_on,
	output logic             input_filter_on,
	output logic             input_filter_high,
	output logic [1:0]       input_source,
	output logic [9:0]       mpu_base,
	output logic [3:0]       mpu_irq,
	output logic [9:0]       gameport_base,

	// configuration write channel
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic        cfg_index,
	input  wire logic [15:0] cfg_data
);

	// configuration registers
	logic [15:0] base_address_q;
	logic [3:0]  dsp_irq_q;

	// mixer state
	amrf_pkg::mix_regs_t regs_q, regs_d;
	logic [7:0] index_q, index_d;
	logic [1:0] id_ptr_q, id_ptr_d;

	// result register
	logic           out_valid_q;
	logic [7:0]     read_data_q;
	amrf_pkg::ctl_t ctl_q;

	logic           accept;
	logic [7:0]     rd_d;
	amrf_pkg::ctl_t ctl_d;

	// stall only when a finished result has not been taken
	assign in_stall  = out_valid_q & out_stall;
	assign accept    = in_valid & ~in_stall;
	assign cfg_ready = 1'b1;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_address_q <= amrf_pkg::BASE_ADDRESS_RST;
			dsp_irq_q      <= amrf_pkg::DSP_IRQ_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				amrf_pkg::CFG_BASE_ADDRESS: base_address_q <= cfg_data;
				amrf_pkg::CFG_DSP_IRQ:      dsp_irq_q      <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	// next state and read data of one transaction
	always_comb begin
		regs_d   = regs_q;
		index_d  = index_q;
		id_ptr_d = id_ptr_q;
		rd_d     = 8'h00;

		if (accept) begin
			if (opcode == amrf_pkg::OP_WRITE) begin
				if (port_select == amrf_pkg::PORT_INDEX) begin
					// register 01 mirror is never readable, only the index is kept
					index_d = write_data;
					if (write_data == amrf_pkg::IDX_ID_CTRL) begin
						id_ptr_d = amrf_pkg::ID_PTR_B0;
					end
				end else begin
					case (index_q)
						amrf_pkg::IDX_RESET: begin
							// default load, the byte itself is dropped
							regs_d.r0a = 8'h00;
							regs_d.r0c = 8'h00;
							regs_d.r0e = 8'h00;
							regs_d.r04 = amrf_pkg::VOL_DEFAULT_HI;
							regs_d.r22 = amrf_pkg::VOL_DEFAULT_HI;
							regs_d.r26 = amrf_pkg::VOL_DEFAULT_HI;
							regs_d.r28 = amrf_pkg::VOL_DEFAULT_HI;
							regs_d.r2e = 8'h00;
							regs_d.r32 = amrf_pkg::VOL_DEFAULT_LO;
							regs_d.r36 = amrf_pkg::VOL_DEFAULT_LO;
							regs_d.r38 = 8'h00;
						end
						// mono writes fan out to both stereo nibbles
						amrf_pkg::IDX_MASTER_MONO: begin
							regs_d.r02 = write_data;
							regs_d.r22 = {write_data[3:1], 1'b0, write_data[3:1], 1'b0};
						end
						amrf_pkg::IDX_FM_MONO: begin
							regs_d.r06 = write_data;
							regs_d.r26 = {write_data[3:1], 1'b0, write_data[3:1], 1'b0};
						end
						amrf_pkg::IDX_CD_MONO: begin
							regs_d.r28 = {write_data[3:1], 1'b0, write_data[3:1], 1'b0};
						end
						amrf_pkg::IDX_VOICE_ALT: begin
							regs_d.r04 = write_data & amrf_pkg::VOL_MASK_ST;
						end
						// stereo writes feed the mono copy and the upper alias, where those are stored
						amrf_pkg::IDX_MASTER: begin
							regs_d.r22 = write_data;
							regs_d.r02 = write_data & amrf_pkg::VOL_MASK_MONO;
							regs_d.r32 = write_data;
						end
						amrf_pkg::IDX_FM: begin
							regs_d.r26 = write_data;
							regs_d.r06 = write_data & amrf_pkg::VOL_MASK_MONO;
							regs_d.r36 = write_data;
						end
						amrf_pkg::IDX_CD: begin
							regs_d.r28 = write_data;
							regs_d.r38 = write_data;
						end
						amrf_pkg::IDX_LINE: begin
							regs_d.r2e = write_data;
							regs_d.r0e = write_data & amrf_pkg::VOL_MASK_MONO;
						end
						// upper aliases write back down, except register 30
						amrf_pkg::IDX_ALT30: regs_d.r30 = write_data;
						amrf_pkg::IDX_ALT32: begin
							regs_d.r32 = write_data;
							regs_d.r22 = write_data & amrf_pkg::VOL_MASK_ST;
						end
						amrf_pkg::IDX_ALT36: begin
							regs_d.r36 = write_data;
							regs_d.r26 = write_data & amrf_pkg::VOL_MASK_ST;
						end
						amrf_pkg::IDX_ALT38: begin
							regs_d.r38 = write_data;
							regs_d.r28 = write_data & amrf_pkg::VOL_MASK_ST;
						end
						amrf_pkg::IDX_ALT3E: regs_d.r2e = write_data & amrf_pkg::VOL_MASK_ST;
						amrf_pkg::IDX_VOICE:    regs_d.r04 = write_data;
						amrf_pkg::IDX_MIC:      regs_d.r0a = write_data;
						amrf_pkg::IDX_IN_CTRL:  regs_d.r0c = write_data;
						amrf_pkg::IDX_OUT_CTRL: regs_d.r0e = write_data;
						amrf_pkg::IDX_ID_CTRL:  regs_d.r40 = write_data;
						default: ;
					endcase
				end
			end else if (port_select == amrf_pkg::PORT_INDEX) begin
				rd_d = index_q;
			end else begin
				case (index_q)
					// register 00 is never stored, so it reads zero
					amrf_pkg::IDX_RESET:       rd_d = 8'h00;
					amrf_pkg::IDX_MASTER_MONO: rd_d = regs_q.r02;
					amrf_pkg::IDX_VOICE:       rd_d = regs_q.r04;
					amrf_pkg::IDX_FM_MONO:     rd_d = regs_q.r06;
					amrf_pkg::IDX_MIC:         rd_d = regs_q.r0a;
					amrf_pkg::IDX_IN_CTRL:     rd_d = regs_q.r0c;
					amrf_pkg::IDX_OUT_CTRL:    rd_d = regs_q.r0e;
					amrf_pkg::IDX_MASTER:      rd_d = regs_q.r22;
					amrf_pkg::IDX_FM:          rd_d = regs_q.r26;
					amrf_pkg::IDX_CD:          rd_d = regs_q.r28;
					amrf_pkg::IDX_LINE:        rd_d = regs_q.r2e;
					amrf_pkg::IDX_ALT30:       rd_d = regs_q.r30;
					amrf_pkg::IDX_ALT32:       rd_d = regs_q.r32;
					amrf_pkg::IDX_ALT36:       rd_d = regs_q.r36;
					amrf_pkg::IDX_ALT38:       rd_d = regs_q.r38;
					amrf_pkg::IDX_ID_CTRL: begin
						// rotating id bytes, pointer wraps after four
						case (id_ptr_q)
							amrf_pkg::ID_PTR_B0: rd_d = amrf_pkg::ID_BYTE0;
							amrf_pkg::ID_PTR_B1: rd_d = amrf_pkg::ID_BYTE1;
							amrf_pkg::ID_PTR_B2: rd_d = base_address_q[15:8];
							default:             rd_d = base_address_q[7:0];
						endcase
						id_ptr_d = id_ptr_q + 2'd1;
					end
					default: rd_d = amrf_pkg::UNMAPPED_READ;
				endcase
			end
		end
	end

	// controls are decoded from the post-transaction registers
	amrf_ctl_decode u_ctl_decode (
		.r0c     (regs_d.r0c),
		.r0e     (regs_d.r0e),
		.r40     (regs_d.r40),
		.dsp_irq (dsp_irq_q),
		.ctl     (ctl_d)
	);

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q   <= amrf_pkg::MIX_RESET;
			index_q  <= 8'h00;
			id_ptr_q <= amrf_pkg::ID_PTR_B0;
		end else begin
			regs_q   <= regs_d;
			index_q  <= index_d;
			id_ptr_q <= id_ptr_d;
		end
	end

	// output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// output payload
	always_ff @(posedge clk) begin
		if (accept) begin
			read_data_q <= rd_d;
			ctl_q       <= ctl_d;
		end
	end

	assign out_valid         = out_valid_q;
	assign read_data         = read_data_q;
	assign stereo_on         = ctl_q.stereo_on;
	assign output_filter_on  = ctl_q.output_filter_on;
	assign input_filter_on   = ctl_q.input_filter_on;
	assign input_filter_high = ctl_q.input_filter_high;
	assign input_source      = ctl_q.input_source;
	assign mpu_base          = ctl_q.mpu_base;
	assign mpu_irq           = ctl_q.mpu_irq;
	assign gameport_base     = ctl_q.gameport_base;

`ifndef SYNTHESIS
	// a write transaction always returns zero read data
	a_write_reads_zero: assert property (@(posedge clk) disable iff (!arst_n)
		accept && opcode == amrf_pkg::OP_WRITE |=> out_valid && read_data == 8'h00)
		else $error("write transaction returned nonzero read data");

	// register 00 is never stored and reads back zero
	a_reg00_zero: assert property (@(posedge clk) disable iff (!arst_n)
		accept && opcode == amrf_pkg::OP_READ && port_select == amrf_pkg::PORT_DATA
		&& index_q == amrf_pkg::IDX_RESET |=> read_data == 8'h00)
		else $error("register 00 read returned nonzero data");

	// selecting the id register rewinds the id sequence
	a_id_rewind: assert property (@(posedge clk) disable iff (!arst_n)
		accept && opcode == amrf_pkg::OP_WRITE && port_select == amrf_pkg::PORT_INDEX
		&& write_data == amrf_pkg::IDX_ID_CTRL |=> id_ptr_q == amrf_pkg::ID_PTR_B0)
		else $error("id pointer not rewound on index write");

	// stall only while a result is held
	a_stall_needs_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid_q)
		else $error("input stalled without a pending result");

	// game port decodes to one of two addresses
	a_gameport_values: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> gameport_base == 10'h000 || gameport_base == amrf_pkg::JOYSTICK_BASE)
		else $error("game port base out of range");
`endif

endmodule
`default_nettype wire

>>> hw/rtl/amrf_ctl_decode.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// amrf_ctl_decode
// decodes stereo, filter, source, mpu and game port controls from registers
// ----------------------------------------------------------------------------
module amrf_ctl_decode (
	input  wire logic [7:0]     r0c,
	input  wire logic [7:0]     r0e,
	input  wire logic [7:0]     r40,
	input  wire logic [3:0]     dsp_irq,
	output amrf_pkg::ctl_t      ctl
);

	logic [2:0] mode;

	assign mode = r40[7:5];

	always_comb begin
		ctl.stereo_on         = r0e[1];
		ctl.output_filter_on  = ~r0e[5];
		ctl.input_filter_on   = ~r0c[5];
		ctl.input_filter_high = r0c[3];

		case (r0c[2:1])
			amrf_pkg::SEL_CD:   ctl.input_source = amrf_pkg::SRC_CD;
			amrf_pkg::SEL_LINE: ctl.input_source = amrf_pkg::SRC_LINE;
			default:            ctl.input_source = amrf_pkg::SRC_MIC;
		endcase

		if (mode == amrf_pkg::MPU_MODE_OFF) begin
			ctl.mpu_base = '0;
		end else begin
			ctl.mpu_base = amrf_pkg::MPU_BASE_MIN | {3'b000, r40[5:3], 4'b0000};
		end

		case (mode)
			amrf_pkg::MPU_MODE_DSP:  ctl.mpu_irq = dsp_irq;
			amrf_pkg::MPU_MODE_IRQE: ctl.mpu_irq = 4'hE;
			amrf_pkg::MPU_MODE_IRQA: ctl.mpu_irq = 4'hA;
			amrf_pkg::MPU_MODE_IRQB: ctl.mpu_irq = 4'hB;
			amrf_pkg::MPU_MODE_IRQC: ctl.mpu_irq = 4'hC;
			amrf_pkg::MPU_MODE_IRQD: ctl.mpu_irq = 4'hD;
			default:                 ctl.mpu_irq = 4'h0;
		endcase

		ctl.gameport_base = r40[1] ? amrf_pkg::JOYSTICK_BASE : 10'h000;
	end

endmodule
`default_nettype wire

>>> dv/audio_mixer_register_file_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// audio_mixer_register_file_top_tb
// self-checking bench for the mixer register file: directed and random
// accesses on the index and data ports, each result compared field by field
// with a shadow copy of the registers, under random idling on both channels
// ----------------------------------------------------------------------------
module audio_mixer_register_file_top_tb;
	import amrf_pkg::*;

	localparam int CLK_HALF     = 10;
	localparam int CYCLE_LIMIT  = 300000;
	localparam int LONG_HOLD    = 48;
	localparam int DRAIN_CYCLES = 8;

	// registers that only the shadow copy needs by name
	localparam logic [7:0] IDX_INDEX_MIRROR = 8'h01;
	localparam logic [7:0] IDX_ALT3A        = 8'h3A;

	typedef struct packed {
		logic [7:0] rd_byte;
		ctl_t       ctl;
	} mixer_result_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic        opcode;
	logic        port_select;
	logic [7:0]  write_data;
	logic        out_valid;
	logic        out_stall;
	logic [7:0]  read_data;
	logic        stereo_on;
	logic        output_filter_on;
	logic        input_filter_on;
	logic        input_filter_high;
	logic [1:0]  input_source;
	logic [9:0]  mpu_base;
	logic [3:0]  mpu_irq;
	logic [9:0]  gameport_base;
	logic        cfg_valid;
	logic        cfg_ready;
	logic        cfg_index;
	logic [15:0] cfg_data;

	audio_mixer_register_file_top uut (.*);

	// shadow copy of the block state and its configuration
	logic [7:0]  shadow_regs [256];
	logic [7:0]  shadow_index;
	logic [1:0]  shadow_id_ptr;
	logic [15:0] shadow_base;
	logic [3:0]  shadow_dsp_irq;

	// results still owed by the block, oldest first
	mixer_result_t pending_results [$];

	int errors        = 0;
	int accesses_sent = 0;
	int cycle_count   = 0;
	int tx_max        = 0;   // longest sender gap drawn per transaction
	int rx_max        = 0;   // longest receiver stall drawn per transaction
	int stall_left    = 0;
	int hold_left     = 0;   // long receiver hold-off, counted down by the receiver

	initial clk = 1'b0;
	always #(CLK_HALF) clk = ~clk;

	// run limit, far above the slowest legal run
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// ------------------------------------------------------------------------
	// shadow model
	// ------------------------------------------------------------------------

	// the registers touched by a data write at index zero
	function automatic void load_mixer_defaults();
		shadow_regs[IDX_MIC]       = 8'h00;
		shadow_regs[IDX_IN_CTRL]   = 8'h00;
		shadow_regs[IDX_OUT_CTRL]  = 8'h00;
		shadow_regs[IDX_VOICE]     = VOL_DEFAULT_HI;
		shadow_regs[IDX_MASTER]    = VOL_DEFAULT_HI;
		shadow_regs[IDX_FM]        = VOL_DEFAULT_HI;
		shadow_regs[IDX_CD]        = VOL_DEFAULT_HI;
		shadow_regs[IDX_LINE]      = 8'h00;
		shadow_regs[IDX_VOICE_ALT] = VOL_DEFAULT_LO;
		shadow_regs[IDX_ALT32]     = VOL_DEFAULT_LO;
		shadow_regs[IDX_ALT36]     = VOL_DEFAULT_LO;
		shadow_regs[IDX_ALT38]     = 8'h00;
		shadow_regs[IDX_ALT3A]     = 8'h00;
		shadow_regs[IDX_ALT3E]     = 8'h00;
	endfunction

	// applies one access to the shadow state and returns the result it owes
	function automatic mixer_result_t predict_access(input logic op, input logic port,
			input logic [7:0] v);
		mixer_result_t res;
		logic [7:0]    ix;
		logic [7:0]    r0c;
		logic [7:0]    r0e;
		logic [7:0]    r40;
		logic [2:0]    mode;
		res = '0;
		ix = shadow_index;
		if (op == OP_WRITE && port == PORT_INDEX) begin
			shadow_index = v;
			shadow_regs[IDX_INDEX_MIRROR] = v;
			if (v == IDX_ID_CTRL) begin
				shadow_id_ptr = ID_PTR_B0;
			end
		end else if (op == OP_WRITE) begin
			if (ix == IDX_RESET) begin
				load_mixer_defaults();
			end else begin
				shadow_regs[ix] = v;
				// mono and stereo alias chains
				case (ix)
					IDX_MASTER_MONO, IDX_FM_MONO, IDX_CD_MONO: begin
						shadow_regs[ix + 8'h20] = ((v & VOL_MASK_MONO) << 4) | (v & VOL_MASK_MONO);
					end
					IDX_VOICE_ALT: begin
						shadow_regs[IDX_VOICE] = v & VOL_MASK_ST;
					end
					IDX_MASTER, IDX_FM, IDX_CD, IDX_LINE: begin
						shadow_regs[ix - 8'h20] = v & VOL_MASK_MONO;
						shadow_regs[ix + 8'h10] = v;
					end
					IDX_ALT30, IDX_ALT32, IDX_ALT36, IDX_ALT38, IDX_ALT3E: begin
						shadow_regs[ix - 8'h10] = v & VOL_MASK_ST;
					end
					default: ;
				endcase
			end
		end else if (port == PORT_INDEX) begin
			res.rd_byte = shadow_index;
		end else begin
			case (ix)
				IDX_RESET, IDX_MASTER_MONO, IDX_VOICE, IDX_FM_MONO, IDX_MIC, IDX_IN_CTRL,
				IDX_OUT_CTRL, IDX_MASTER, IDX_FM, IDX_CD, IDX_LINE, IDX_ALT30, IDX_ALT32,
				IDX_ALT36, IDX_ALT38: begin
					res.rd_byte = shadow_regs[ix];
				end
				IDX_ID_CTRL: begin
					case (shadow_id_ptr)
						ID_PTR_B0: res.rd_byte = ID_BYTE0;
						ID_PTR_B1: res.rd_byte = ID_BYTE1;
						ID_PTR_B2: res.rd_byte = shadow_base[15:8];
						default:   res.rd_byte = shadow_base[7:0];
					endcase
					shadow_id_ptr = shadow_id_ptr + 2'd1;
				end
				default: res.rd_byte = UNMAPPED_READ;
			endcase
		end

		// controls decoded from the registers after the access
		r0c = shadow_regs[IDX_IN_CTRL];
		r0e = shadow_regs[IDX_OUT_CTRL];
		r40 = shadow_regs[IDX_ID_CTRL];
		mode = r40[7:5];
		res.ctl.stereo_on         = r0e[1];
		res.ctl.output_filter_on  = ~r0e[5];
		res.ctl.input_filter_on   = ~r0c[5];
		res.ctl.input_filter_high = r0c[3];
		case (r0c[2:1])
			SEL_CD:   res.ctl.input_source = SRC_CD;
			SEL_LINE: res.ctl.input_source = SRC_LINE;
			default:  res.ctl.input_source = SRC_MIC;
		endcase
		res.ctl.mpu_base = (mode == MPU_MODE_OFF) ? 10'h000
			: (MPU_BASE_MIN | {3'b000, r40[5:3], 4'b0000});
		case (mode)
			MPU_MODE_DSP:  res.ctl.mpu_irq = shadow_dsp_irq;
			MPU_MODE_IRQE: res.ctl.mpu_irq = 4'hE;
			MPU_MODE_IRQA: res.ctl.mpu_irq = 4'hA;
			MPU_MODE_IRQB: res.ctl.mpu_irq = 4'hB;
			MPU_MODE_IRQC: res.ctl.mpu_irq = 4'hC;
			MPU_MODE_IRQD: res.ctl.mpu_irq = 4'hD;
			default:       res.ctl.mpu_irq = 4'h0;
		endcase
		res.ctl.gameport_base = r40[1] ? JOYSTICK_BASE : 10'h000;
		return res;
	endfunction

	// ------------------------------------------------------------------------
	// result side
	// ------------------------------------------------------------------------

	task automatic check_field(input string name, input logic [15:0] want_v,
			input logic [15:0] got_v);
		if (got_v !== want_v) begin
			errors++;
			$display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want_v,
				got_v);
		end
	endtask

	// every accepted result is matched against the oldest expectation
	always @(posedge clk) begin : result_check
		mixer_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				errors++;
				$display("%0t: result with nothing expected, expected none, actual 0x%0h",
					$time, read_data);
			end else begin
				want = pending_results.pop_front();
				check_field("read_data", 16'(want.rd_byte), 16'(read_data));
				check_field("stereo_on", 16'(want.ctl.stereo_on), 16'(stereo_on));
				check_field("output_filter_on", 16'(want.ctl.output_filter_on),
					16'(output_filter_on));
				check_field("input_filter_on", 16'(want.ctl.input_filter_on),
					16'(input_filter_on));
				check_field("input_filter_high", 16'(want.ctl.input_filter_high),
					16'(input_filter_high));
				check_field("input_source", 16'(want.ctl.input_source), 16'(input_source));
				check_field("mpu_base", 16'(want.ctl.mpu_base), 16'(mpu_base));
				check_field("mpu_irq", 16'(want.ctl.mpu_irq), 16'(mpu_irq));
				check_field("gameport_base", 16'(want.ctl.gameport_base),
					16'(gameport_base));
			end
			// stall before the next transaction
			stall_left = $urandom_range(0, rx_max);
		end
	end

	// receiver: the long hold-off wins over the per-transaction stall
	initial out_stall = 1'b0;
	always @(negedge clk) begin
		if (hold_left > 0) begin
			out_stall <= 1'b1;
			hold_left--;
		end else if (stall_left > 0) begin
			out_stall <= 1'b1;
			stall_left--;
		end else begin
			out_stall <= 1'b0;
		end
	end

	// ------------------------------------------------------------------------
	// access side
	// ------------------------------------------------------------------------

	// one transaction on the access channel, predicted at its accepting edge
	task automatic send_access(input logic op, input logic port, input logic [7:0] v);
		int gap;
		gap = $urandom_range(0, tx_max);
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid    <= 1'b1;
		opcode      <= op;
		port_select <= port;
		write_data  <= v;
		do @(posedge clk); while (in_stall);
		pending_results.push_back(predict_access(op, port, v));
		accesses_sent++;
	endtask

	task automatic send_noise();
		send_access(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
			8'($urandom_range(0, 255)));
	endtask

	// drop valid and let every owed result come back
	task automatic wait_idle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
	endtask

	// configuration transaction, only issued while idle
	task automatic write_config(input logic idx, input logic [15:0] value);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		if (idx == CFG_BASE_ADDRESS) begin
			shadow_base = value;
		end else begin
			shadow_dsp_irq = value[3:0];
		end
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// ------------------------------------------------------------------------
	// tests
	// ------------------------------------------------------------------------

	// index readback and register zero straight out of reset
	task automatic test_reset_state();
		send_access(OP_READ, PORT_INDEX, 8'h00);
		send_access(OP_READ, PORT_DATA, 8'hFF);
	endtask

	// mono to stereo, stereo to mono and the voice alias
	task automatic test_alias_chains();
		send_access(OP_WRITE, PORT_INDEX, IDX_MASTER_MONO);
		send_access(OP_WRITE, PORT_DATA, 8'hFF);
		send_access(OP_WRITE, PORT_INDEX, IDX_MASTER);
		send_access(OP_READ, PORT_DATA, 8'h00);
		send_access(OP_WRITE, PORT_DATA, 8'h00);
		send_access(OP_WRITE, PORT_INDEX, IDX_VOICE_ALT);
		send_access(OP_WRITE, PORT_DATA, 8'hFF);
	endtask

	// stereo, filters, input source, mpu and game port decode
	task automatic test_control_decode();
		send_access(OP_WRITE, PORT_INDEX, IDX_OUT_CTRL);
		send_access(OP_WRITE, PORT_DATA, 8'h22);
		send_access(OP_WRITE, PORT_INDEX, IDX_IN_CTRL);
		send_access(OP_WRITE, PORT_DATA, 8'h2E);
		send_access(OP_WRITE, PORT_INDEX, IDX_ID_CTRL);
		send_access(OP_WRITE, PORT_DATA, 8'h5A);   // mpu on the dsp irq, game port on
		send_access(OP_WRITE, PORT_DATA, 8'hFE);   // highest mpu mode and address
	endtask

	// id bytes rotate and wrap after four reads
	task automatic test_id_readout();
		send_access(OP_WRITE, PORT_INDEX, IDX_ID_CTRL);
		repeat (5) send_access(OP_READ, PORT_DATA, 8'h00);
	endtask

	// a register off the readable list reads all ones
	task automatic test_unmapped_read();
		send_access(OP_WRITE, PORT_INDEX, 8'hFF);
		send_access(OP_READ, PORT_DATA, 8'h00);
	endtask

	// data write at index zero restores the defaults and stores nothing
	task automatic test_default_load();
		send_access(OP_WRITE, PORT_INDEX, IDX_RESET);
		send_access(OP_WRITE, PORT_DATA, 8'hA5);
	endtask

	// configuration extremes and a random setting, seen through the id bytes and mpu mode 2
	task automatic test_config_settings();
		int k;
		for (k = 0; k < 3; k++) begin
			wait_idle();
			write_config(CFG_BASE_ADDRESS, (k == 0) ? 16'h0000 : (k == 1) ? 16'hFFFF
				: 16'($urandom_range(0, 16'hFFFF)));
			write_config(CFG_DSP_IRQ, (k == 0) ? 16'd0 : (k == 1) ? 16'd15
				: 16'($urandom_range(0, 15)));
			send_access(OP_WRITE, PORT_INDEX, IDX_ID_CTRL);
			send_access(OP_WRITE, PORT_DATA, 8'h40);   // mpu irq follows the dsp irq
			repeat (4) send_access(OP_READ, PORT_DATA, 8'h00);
		end
	endtask

	// receiver holds off while the sender keeps offering back to back
	task automatic test_backpressure();
		wait_idle();
		@(posedge clk);
		hold_left = LONG_HOLD;
		tx_max = 0;
		rx_max = 3;
		repeat (20) send_noise();
	endtask

	// mostly an index write followed by a short burst of data accesses
	task automatic test_random_traffic(input int count, input int tx_lim, input int rx_lim);
		int         target;
		int         burst;
		int         r;
		logic [7:0] ix;
		wait_idle();
		write_config(CFG_BASE_ADDRESS, 16'($urandom_range(0, 16'hFFFF)));
		write_config(CFG_DSP_IRQ, 16'($urandom_range(0, 15)));
		tx_max = tx_lim;
		rx_max = rx_lim;
		target = accesses_sent + count;
		while (accesses_sent < target) begin
			if ($urandom_range(0, 9) < 7) begin
				case ($urandom_range(0, 24))
					0:  ix = IDX_RESET;
					1:  ix = IDX_MASTER_MONO;
					2:  ix = IDX_VOICE;
					3:  ix = IDX_FM_MONO;
					4:  ix = IDX_CD_MONO;
					5:  ix = IDX_MIC;
					6:  ix = IDX_IN_CTRL;
					7:  ix = IDX_OUT_CTRL;
					8:  ix = IDX_VOICE_ALT;
					9:  ix = IDX_MASTER;
					10: ix = IDX_FM;
					11: ix = IDX_CD;
					12: ix = IDX_LINE;
					13: ix = IDX_ALT30;
					14: ix = IDX_ALT32;
					15: ix = IDX_ALT36;
					16: ix = IDX_ALT38;
					17: ix = IDX_ALT3E;
					18: ix = IDX_ALT3A;
					19: ix = IDX_ID_CTRL;
					20: ix = IDX_ID_CTRL;
					default: ix = 8'($urandom_range(0, 255));
				endcase
				send_access(OP_WRITE, PORT_INDEX, ix);
				burst = $urandom_range(1, 4);
				repeat (burst) begin
					r = $urandom_range(0, 7);
					if (r == 0) begin
						send_access(OP_READ, PORT_INDEX, 8'($urandom_range(0, 255)));
					end else if (r < 4) begin
						send_access(OP_READ, PORT_DATA, 8'($urandom_range(0, 255)));
					end else begin
						send_access(OP_WRITE, PORT_DATA, 8'($urandom_range(0, 255)));
					end
				end
			end else begin
				send_noise();
			end
		end
	endtask

	// ------------------------------------------------------------------------
	// sequence
	// ------------------------------------------------------------------------
	initial begin : stimulus
		int i;
		arst_n      = 1'b0;
		in_valid    = 1'b0;
		opcode      = OP_READ;
		port_select = PORT_INDEX;
		write_data  = 8'h00;
		cfg_valid   = 1'b0;
		cfg_index   = CFG_BASE_ADDRESS;
		cfg_data    = 16'h0000;
		for (i = 0; i < 256; i++) begin
			shadow_regs[i] = 8'h00;
		end
		load_mixer_defaults();
		shadow_index   = 8'h00;
		shadow_id_ptr  = ID_PTR_B0;
		shadow_base    = BASE_ADDRESS_RST;
		shadow_dsp_irq = DSP_IRQ_RST;
		tx_max = 4;
		rx_max = 4;

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_reset_state();
		test_alias_chains();
		test_control_decode();
		test_id_readout();
		test_unmapped_read();
		test_default_load();
		test_config_settings();
		test_random_traffic(270, 16, 16);
		test_random_traffic(270, 0, 0);
		test_backpressure();
		test_random_traffic(270, 16, 0);
		test_random_traffic(270, 0, 16);

		wait_idle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule

>>> filelist.f
hw/rtl/amrf_pkg.sv
hw/rtl/amrf_ctl_decode.sv
hw/rtl/audio_mixer_register_file_top.sv
dv/audio_mixer_register_file_top_tb.sv
